[sv/triangle_cull_and_scan_convert_assert.svh]
// Assertion macros shared by the checker of the triangle span generator.
// Depends on nothing; included by the checker file.
`ifndef TRIANGLE_CULL_AND_SCAN_CONVERT_ASSERT_SVH
`define TRIANGLE_CULL_AND_SCAN_CONVERT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define TCSC_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("tcsc assertion failed");

// Next-cycle implication, disabled during reset
`define TCSC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("tcsc assertion failed");

`endif

[sv/tcsc_pkg.sv]
// Shared constants and types for the triangle cull and span generator.
// No dependencies; imported by the top level and its checker.
package tcsc_pkg;

	localparam int SCREEN_W = 128;
	localparam int SCREEN_H = 64;

	// Coordinate, edge accumulator and divider widths
	localparam int CW   = 16;
	localparam int EW   = 36;
	localparam int QW   = 32;
	localparam int DW   = 17;
	localparam int FW   = 16;
	localparam int YW   = 18;
	localparam int PW   = 20;
	localparam int CNTW = $clog2(QW);

	// Sequencer states, one-hot
	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_MUL1  = 10'b0000000010,
		ST_MUL2  = 10'b0000000100,
		ST_CMP   = 10'b0000001000,
		ST_SORT1 = 10'b0000010000,
		ST_SORT2 = 10'b0000100000,
		ST_SORT3 = 10'b0001000000,
		ST_DSET  = 10'b0010000000,
		ST_DIV   = 10'b0100000000,
		ST_WALK  = 10'b1000000000
	} state_t;

	// Edge selected for the divider
	typedef enum logic [1:0] {
		EDGE_TB = 2'd0,
		EDGE_TM = 2'd1,
		EDGE_MB = 2'd2
	} edge_sel_t;

endpackage

[sv/triangle_cull_and_scan_convert.sv]
// Triangle cull and scanline span generator. One triangle is taken while in_ready is high;
// the block then stays busy for the cull test and sort, for edge setup on one shared
// 1-bit-per-cycle restoring divider (three 32-bit divisions), for the walk of each row
// from the top vertex y to min(bottom y, SCREEN_H-1) and for a closing step, plus any
// cycles spent waiting on out_ready. Rows above the screen are walked too, one per cycle.
// A culled triangle returns to idle after the cull test. Each visible row yields one
// span word; last_span marks the final one. Depends on tcsc_pkg.
module triangle_cull_and_scan_convert import tcsc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] a_x,
	input  logic signed [15:0] a_y,
	input  logic signed [15:0] b_x,
	input  logic signed [15:0] b_y,
	input  logic signed [15:0] c_x,
	input  logic signed [15:0] c_y,
	input  logic        [7:0]  shade,
	output logic               out_valid,
	input  logic               out_ready,
	output logic        [5:0]  row,
	output logic        [7:0]  left_x,
	output logic signed [7:0]  right_x,
	output logic        [20:0] fill_color,
	output logic               last_span
);

	state_t state_q;
	edge_sel_t sel_q;

	logic signed [CW-1:0] x1_q, y1_q, x2_q, y2_q, x3_q, y3_q;
	logic [7:0] shade_q;
	logic signed [2*YW-1:0] p1_q, p2_q;
	logic [DW:0] rem_q;
	logic [QW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic neg_q;
	logic [CNTW-1:0] cnt_q;
	logic signed [EW-1:0] s_tb_q, s_tm_q, s_mb_q, e1_q, e2_q;
	logic signed [YW-1:0] ycur_q;
	logic out_valid_q;

	// Shared multiplier for the winding test
	logic signed [YW-1:0] mul_a, mul_b;
	logic signed [2*YW-1:0] prod;
	always_comb begin
		if (state_q == ST_MUL1) begin
			mul_a = YW'(x2_q) - YW'(x1_q) + YW'(1);
			mul_b = YW'(y3_q) - YW'(y1_q) + YW'(1);
		end else begin
			mul_a = YW'(x3_q) - YW'(x1_q) + YW'(1);
			mul_b = YW'(y2_q) - YW'(y1_q) + YW'(1);
		end
	end
	assign prod = mul_a * mul_b;

	// Divider operands for the selected edge
	logic signed [CW:0] ddx, ddy;
	logic [CW:0] dmag;
	always_comb begin
		unique case (sel_q)
			EDGE_TB: begin
				ddx = (CW+1)'(x3_q) - (CW+1)'(x1_q);
				ddy = (CW+1)'(y3_q) - (CW+1)'(y1_q);
			end
			EDGE_TM: begin
				ddx = (CW+1)'(x2_q) - (CW+1)'(x1_q);
				ddy = (CW+1)'(y2_q) - (CW+1)'(y1_q);
			end
			default: begin
				ddx = (CW+1)'(x3_q) - (CW+1)'(x2_q);
				ddy = (CW+1)'(y3_q) - (CW+1)'(y2_q);
			end
		endcase
		dmag = ddx[CW] ? -ddx : ddx;
	end

	// One restoring divide step
	logic [DW:0] trial, rem_nx;
	logic qbit;
	logic [QW-1:0] quo_nx;
	logic signed [EW-1:0] q_ext, slope_nx;
	always_comb begin
		trial = {rem_q[DW-1:0], quo_q[QW-1]};
		qbit = (trial >= {1'b0, den_q});
		rem_nx = qbit ? trial - {1'b0, den_q} : trial;
		quo_nx = {quo_q[QW-2:0], qbit};
		q_ext = EW'(quo_nx);
		slope_nx = neg_q ? -q_ext : q_ext;
	end

	// Span of the current row
	logic signed [PW-1:0] fl1, fl2, lo, hi;
	logic signed [PW-1:0] lcl, rcl;
	logic out_free, row_vis, walk_done, is_last, span_load;
	always_comb begin
		fl1 = e1_q[EW-1:FW];
		fl2 = e2_q[EW-1:FW];
		lo = (fl1 > fl2) ? fl2 : fl1;
		hi = (fl1 > fl2) ? fl1 : fl2;
		lcl = lo;
		if (lo < 0) lcl = '0;
		if (lo >= PW'(SCREEN_W)) lcl = PW'(SCREEN_W);
		rcl = hi;
		if (hi < 0) rcl = -PW'(1);
		if (hi >= PW'(SCREEN_W)) rcl = PW'(SCREEN_W - 1);
		out_free = !out_valid_q || out_ready;
		walk_done = (ycur_q > YW'(y3_q)) || (ycur_q >= YW'(SCREEN_H));
		row_vis = (ycur_q >= 0);
		is_last = (ycur_q == YW'(y3_q)) || (ycur_q == YW'(SCREEN_H - 1));
		span_load = (state_q == ST_WALK) && !walk_done && row_vis && out_free;
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q <= EDGE_TB;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Raise on a new span word, hold until accepted
			out_valid_q <= span_load || (out_valid_q && !out_ready);
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_CMP;
				ST_CMP: state_q <= (p1_q < p2_q) ? ST_SORT1 : ST_IDLE;
				ST_SORT1: state_q <= ST_SORT2;
				ST_SORT2: state_q <= ST_SORT3;
				ST_SORT3: begin
					state_q <= ST_DSET;
					sel_q <= EDGE_TB;
				end
				ST_DSET: begin
					state_q <= ST_DIV;
					cnt_q <= '0;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNTW'(1);
					if (cnt_q == CNTW'(QW - 1)) begin
						if (sel_q == EDGE_MB) begin
							state_q <= ST_WALK;
						end else begin
							state_q <= ST_DSET;
							sel_q <= (sel_q == EDGE_TB) ? EDGE_TM : EDGE_MB;
						end
					end
				end
				ST_WALK: if (walk_done) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (in_valid) begin
				x1_q <= a_x; y1_q <= a_y;
				x2_q <= b_x; y2_q <= b_y;
				x3_q <= c_x; y3_q <= c_y;
				shade_q <= shade;
			end
			ST_MUL1: p1_q <= prod;
			ST_MUL2: p2_q <= prod;
			ST_SORT1, ST_SORT3: if (y1_q > y2_q) begin
				x1_q <= x2_q; x2_q <= x1_q;
				y1_q <= y2_q; y2_q <= y1_q;
			end
			ST_SORT2: if (y2_q > y3_q) begin
				x2_q <= x3_q; x3_q <= x2_q;
				y2_q <= y3_q; y3_q <= y2_q;
			end
			ST_DSET: begin
				rem_q <= '0;
				quo_q <= {dmag[CW-1:0], {FW{1'b0}}};
				den_q <= (ddy == 0) ? DW'(1 << FW) : ddy[DW-1:0];
				neg_q <= ddx[CW];
			end
			ST_DIV: begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				if (cnt_q == CNTW'(QW - 1)) begin
					unique case (sel_q)
						EDGE_TB: s_tb_q <= slope_nx;
						EDGE_TM: s_tm_q <= slope_nx;
						default: s_mb_q <= slope_nx;
					endcase
					// Set up the walk at the top vertex
					if (sel_q == EDGE_MB) begin
						e1_q <= (y1_q == y2_q) ? EW'(x2_q) <<< FW : EW'(x1_q) <<< FW;
						e2_q <= EW'(x1_q) <<< FW;
						ycur_q <= YW'(y1_q);
					end
				end
			end
			ST_WALK: begin
				if (!walk_done && (!row_vis || out_free)) begin
					if (row_vis) begin
						row <= ycur_q[5:0];
						left_x <= lcl[7:0];
						right_x <= rcl[7:0];
						fill_color <= {shade_q[7:3], 2'b00, shade_q[7:2], shade_q};
						last_span <= is_last;
					end
					e1_q <= e1_q + ((ycur_q < YW'(y2_q)) ? s_tm_q : s_mb_q);
					e2_q <= e2_q + s_tb_q;
					ycur_q <= ycur_q + YW'(1);
				end
			end
			default: ;
		endcase
	end

endmodule

[sv/tcsc_checker.sv]
// Port-level checker for the triangle span generator, bound to the top level.
// Depends on tcsc_pkg and triangle_cull_and_scan_convert_assert.svh.
`include "triangle_cull_and_scan_convert_assert.svh"

module tcsc_checker import tcsc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] left_x,
	input logic       last_span
);

	// Hold a stalled output word
	`TCSC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// Go busy once a triangle word is taken
	`TCSC_ASSERT_NEXT(a_busy_after_in, clk, arst_n, in_valid && in_ready, !in_ready)

	// Keep left edge inside the clamp range
	`TCSC_ASSERT_NOW(a_left_range, clk, arst_n, out_valid, left_x <= 8'(SCREEN_W))

	// Stay busy while spans of the triangle remain
	`TCSC_ASSERT_NEXT(a_more_spans, clk, arst_n, out_valid && out_ready && !last_span, !in_ready)

endmodule

bind triangle_cull_and_scan_convert tcsc_checker u_tcsc_checker (.*);

[tb/triangle_cull_and_scan_convert_tb.sv]
// Testbench for the triangle cull and span generator: directed and random triangles
// against a built-in span predictor, with random idling on both channels.
// Depends on tcsc_pkg and triangle_cull_and_scan_convert.
module triangle_cull_and_scan_convert_tb;
	import tcsc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [5:0]  row;
		logic [7:0]  left_x;
		logic [7:0]  right_x;
		logic [20:0] fill_color;
		logic        last_span;
	} span_t;

	typedef struct {
		longint ax, ay, bx, by, cx, cy;
		int     shade;
	} tri_t;

	// Winding test used by the span predictor
	function automatic bit is_drawn(tri_t t);
		return (t.bx - t.ax + 1) * (t.cy - t.ay + 1) < (t.cx - t.ax + 1) * (t.by - t.ay + 1);
	endfunction

	class span_scoreboard;
		span_t expected_spans[$];
		int    mismatches;

		function longint edge_slope(longint dxfix, longint dy);
			return dxfix / (dy != 0 ? dy : 65536);
		endfunction

		// Walk the rows of one triangle and queue its visible spans
		function void note_triangle(tri_t t);
			longint x1, y1, x2, y2, x3, y3, tmp, s_tb, s_tm, s_mb, e1, e2, l, r, y;
			logic [7:0] sh;
			logic [20:0] color;
			span_t rows[$];
			span_t s;
			if (!is_drawn(t))
				return;
			x1 = t.ax; y1 = t.ay; x2 = t.bx; y2 = t.by; x3 = t.cx; y3 = t.cy;
			sh = t.shade[7:0];
			color = sh + (sh / 4) * 256 + (sh / 8) * 65536;
			if (y1 > y2) begin
				tmp = x1; x1 = x2; x2 = tmp; tmp = y1; y1 = y2; y2 = tmp;
			end
			if (y2 > y3) begin
				tmp = x2; x2 = x3; x3 = tmp; tmp = y2; y2 = y3; y3 = tmp;
			end
			if (y1 > y2) begin
				tmp = x1; x1 = x2; x2 = tmp; tmp = y1; y1 = y2; y2 = tmp;
			end
			s_tb = edge_slope((x3 - x1) * 65536, y3 - y1);
			s_tm = edge_slope((x2 - x1) * 65536, y2 - y1);
			s_mb = edge_slope((x3 - x2) * 65536, y3 - y2);
			e1 = (y1 == y2) ? x2 * 65536 : x1 * 65536;
			e2 = x1 * 65536;
			for (y = y1; y <= y3; y++) begin
				if (y >= SCREEN_H)
					break;
				if (y >= 0 && rows.size() < SCREEN_H) begin
					l = e1 >>> 16;
					r = e2 >>> 16;
					if (l > r) begin
						tmp = l; l = r; r = tmp;
					end
					if (l < 0) l = 0;
					if (l >= SCREEN_W) l = SCREEN_W;
					if (r < 0) r = -1;
					if (r >= SCREEN_W) r = SCREEN_W - 1;
					s.row = y[5:0];
					s.left_x = l[7:0];
					s.right_x = r[7:0];
					s.fill_color = color;
					s.last_span = 1'b0;
					rows.push_back(s);
				end
				e1 += (y < y2) ? s_tm : s_mb;
				e2 += s_tb;
			end
			if (rows.size() > 0)
				rows[rows.size() - 1].last_span = 1'b1;
			foreach (rows[i])
				expected_spans.push_back(rows[i]);
		endfunction

		function void check_span(span_t got);
			span_t want;
			if (expected_spans.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected span word: row=%0d left=%0d right=%0d",
						got.row, got.left_x, $signed(got.right_x));
				return;
			end
			want = expected_spans.pop_front();
			if (got != want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("span mismatch: exp row=%0d l=%0d r=%0d c=%h last=%b",
						want.row, want.left_x, $signed(want.right_x), want.fill_color,
						want.last_span);
					$display("               got row=%0d l=%0d r=%0d c=%h last=%b",
						got.row, got.left_x, $signed(got.right_x), got.fill_color,
						got.last_span);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] a_x = '0, a_y = '0, b_x = '0, b_y = '0, c_x = '0, c_y = '0;
	logic [7:0] shade = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [5:0] row;
	logic [7:0] left_x;
	logic signed [7:0] right_x;
	logic [20:0] fill_color;
	logic last_span;

	span_scoreboard sb = new();
	int send_idle_pct;
	int recv_idle_pct;

	triangle_cull_and_scan_convert dut (.*);

	always #5 clk = ~clk;

	// Hold each triangle word until the block takes it
	task automatic send_triangle(tri_t t);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		a_x <= t.ax[15:0]; a_y <= t.ay[15:0];
		b_x <= t.bx[15:0]; b_y <= t.by[15:0];
		c_x <= t.cx[15:0]; c_y <= t.cy[15:0];
		shade <= t.shade[7:0];
		do @(posedge clk); while (!in_ready);
		sb.note_triangle(t);
	endtask

	// Send a triangle in both windings, so at most one of the two is drawn
	task automatic send_both(longint ax, ay, bx, by, cx, cy, int sh);
		tri_t t;
		t = '{ax, ay, bx, by, cx, cy, sh};
		send_triangle(t);
		t = '{ax, ay, cx, cy, bx, by, sh};
		send_triangle(t);
	endtask

	function automatic longint pick_coord(bit is_y);
		int p;
		p = $urandom_range(99);
		if (p < 3)
			return longint'($signed(16'($urandom)));
		if (is_y)
			return longint'($urandom_range(110)) - 20;
		return longint'($urandom_range(220)) - 60;
	endfunction

	task automatic send_random(int n);
		tri_t t;
		repeat (n) begin
			t.ax = pick_coord(0); t.ay = pick_coord(1);
			t.bx = pick_coord(0); t.by = pick_coord(1);
			t.cx = pick_coord(0); t.cy = pick_coord(1);
			t.shade = $urandom_range(255);
			send_triangle(t);
		end
	endtask

	// Drain span words with random backpressure
	initial begin
		forever begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_span('{row, left_x, right_x, fill_color, last_span});
		end
	end

	initial begin
		send_idle_pct = 19;
		recv_idle_pct = 65;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: shade extremes, flat top, zero height, huge and clipped triangles
		send_both(10, 5, 10, 40, 60, 40, 255);
		send_both(100, 5, 10, 5, 50, 50, 0);
		send_both(0, 20, -50, 20, 200, 20, 128);
		send_both(5, 60, 5, 80, 40, 80, 7);
		send_both(-32768, -32768, -32768, 32767, 32767, 32767, 170);
		send_both(0, -32768, -32768, 32767, 32767, 32767, 85);
		send_both(32767, 30, -32768, 10, 0, 63, 31);
		send_both(-200, -10, 300, 100, 64, 0, 240);
		send_both(60, 40, 10, 5, 10, 40, 1);
		send_both(3, 3, 3, 3, 3, 3, 99);
		in_valid <= 1'b0;

		// Pause the sender until every span has come out
		while (sb.expected_spans.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		send_random(120);
		send_idle_pct = 65;
		recv_idle_pct = 19;
		send_random(120);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random(110);
		in_valid <= 1'b0;

		while (sb.expected_spans.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_spans.size() == 0)
			$display("triangle_cull_and_scan_convert_tb passed");
		else
			$display("triangle_cull_and_scan_convert_tb failed");
		$finish;
	end

	initial begin
		#1_000_000_000;
		$display("triangle_cull_and_scan_convert_tb failed");
		$finish;
	end

endmodule

[sim.f]
+incdir+sv
sv/tcsc_pkg.sv
sv/triangle_cull_and_scan_convert.sv
sv/tcsc_checker.sv
tb/triangle_cull_and_scan_convert_tb.sv
